>>> hw/rtl/emamd_pkg.sv
// ----------------------------------------------------------------------------
// emamd_pkg
// Shared types and constants for the EMA mean/deviation capture block.
// ----------------------------------------------------------------------------
`default_nettype none

package emamd_pkg;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_ALPHA_Q16     = 1'b0,
        CFG_LENGTH_IN_USE = 1'b1
    } cfg_index_t;

    localparam int CFG_DATA_W = 16;

    // Request kinds carried on s_tuser
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic [15:0] ALPHA_RESET  = 16'd655;
    localparam logic [11:0] LENGTH_RESET = 12'd2048;
    localparam logic [16:0] ONE_Q16      = 17'h10000;

    // Compare/subtract steps for position modulo ring depth (depth >= 16)
    localparam int MOD_STEPS = 8;

    // Input transaction payload, last field in the low bits
    typedef struct packed {
        logic [1:0]  pad;
        logic [10:0] position;
        logic [15:0] sample;
        logic [2:0]  channel;
    } req_t;

    // Result transaction payload, last field in the low bits
    typedef struct packed {
        logic [1:0]  pad;
        logic [31:0] stored_deviation;
        logic [15:0] stored_sample;
        logic [10:0] slot;
        logic [31:0] deviation_q16;
        logic [31:0] mean_q16;
        logic [2:0]  channel_out;
    } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/ema_mean_deviation_capture_top.sv
// ----------------------------------------------------------------------------
// ema_mean_deviation_capture_top
// Per-channel EMA of sample mean and mean absolute deviation, with a
// capture ring of (sample, deviation) pairs per channel.
// ----------------------------------------------------------------------------
// Handles one transaction at a time. A push steps through S_CHAN, S_MEAN,
// S_ABS, S_DEVMUL and S_DEVSUM until its result sits in the output
// register; a read loads its result in S_CHAN; a request for a channel at
// or above CHANNELS loads it in S_REJECT and only echoes the channel. A
// push runs the chain through the channel memory: read, mean multiply,
// mean sum, absolute difference, deviation multiply, deviation sum and
// write-back. Per-channel mean, deviation, write slot and fill count live in
// a small synchronous channel memory; the sample/deviation pairs live in a
// ring memory of CHANNELS*RING_DEPTH words. Neither memory is swept: a valid
// bit per channel zeroes the channel state after reset, a second one zeroes
// write slot and fill count after a length write, and a ring slot reads as
// zero until the channel's writes, which always run from slot 0 upward, have
// reached it. The result sits in an output register, so a new request is
// taken while the previous result waits for m_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module ema_mean_deviation_capture_top #(
    parameter int CHANNELS   = 8,
    parameter int RING_DEPTH = 2048
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    // Request stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [31:0]                       s_tdata,   // channel, sample, position
    input  wire logic                              s_tuser,   // req_type

    // Result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [127:0]                           m_tdata,   // channel_out, mean_q16,
                                                              // deviation_q16, slot,
                                                              // stored_sample,
                                                              // stored_deviation

    // Configuration write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire emamd_pkg::cfg_index_t             cfg_index,
    input  wire logic [emamd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SLOT_W   = $clog2(RING_DEPTH);
    localparam int LEN_W    = (SLOT_W + 1 > 12) ? SLOT_W + 1 : 12;
    localparam int ADDR_W   = $clog2(CHANNELS * RING_DEPTH);
    localparam int RING_W   = 48;                       // {deviation, sample}
    localparam int DEV_LSB  = 32;
    localparam int WS_LSB   = 64;
    localparam int FILL_LSB = 64 + SLOT_W;
    localparam int CW_W     = 64 + SLOT_W + LEN_W;      // {fill, wslot, dev, mean}

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHAN,
        S_MEAN,
        S_ABS,
        S_DEVMUL,
        S_DEVSUM,
        S_REJECT
    } state_t;

    state_t state_reg;

    // ------------------------------------------------------------------
    // Configuration and per-channel valid bits
    // ------------------------------------------------------------------
    logic [15:0]         alpha_reg;
    logic [11:0]         length_reg;
    logic [CHANNELS-1:0] chan_valid_reg;   // mean/deviation written since reset
    logic [CHANNELS-1:0] ring_valid_reg;   // write slot/fill written since clear

    logic cfg_we;
    logic cfg_len_we;

    assign cfg_ready  = 1'b1;
    assign cfg_we     = cfg_valid && cfg_ready;
    assign cfg_len_we = cfg_we && (cfg_index == emamd_pkg::CFG_LENGTH_IN_USE);

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    emamd_pkg::req_t     s_req;
    logic                s_accept;
    logic [CH_IDX_W-1:0] idx_in;
    logic                ch_ok_in;
    logic [10:0]         pos_mod;
    logic [SLOT_W-1:0]   rslot_in;

    assign s_req    = emamd_pkg::req_t'(s_tdata);
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign idx_in   = CH_IDX_W'(s_req.channel);
    assign ch_ok_in = (32'(s_req.channel) < CHANNELS);

    // position % RING_DEPTH by restoring compare/subtract
    always_comb
    begin
        pos_mod = s_req.position;
        for (int k = emamd_pkg::MOD_STEPS - 1; k >= 0; k--)
        begin
            if (32'(pos_mod) >= (RING_DEPTH << k))
            begin
                pos_mod = pos_mod - 11'(RING_DEPTH << k);
            end
        end
    end

    assign rslot_in = SLOT_W'(pos_mod);

    // effective ring length: 0 acts as 1, clamp to RING_DEPTH
    logic [LEN_W-1:0] len_eff;

    always_comb
    begin
        if (length_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (32'(length_reg) > RING_DEPTH)
        begin
            len_eff = LEN_W'(RING_DEPTH);
        end
        else
        begin
            len_eff = LEN_W'(length_reg);
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    logic                req_type_reg;
    logic [2:0]          channel_reg;
    logic [15:0]         sample_reg;
    logic [CH_IDX_W-1:0] idx_reg;
    logic [SLOT_W-1:0]   rslot_reg;
    logic                chan_vld_reg;
    logic                ring_vld_reg;
    logic [31:0]         take_mean_reg;     // alpha * sample, Q0.16 * Q16.0
    logic [48:0]         keep_mean_reg;
    logic [31:0]         mean_new_reg;
    logic [48:0]         keep_dev_reg;
    logic [31:0]         diff_reg;
    logic [47:0]         take_dev_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [SLOT_W-1:0]   wslot_next_reg;
    logic [LEN_W-1:0]    fill_next_reg;
    emamd_pkg::result_t  result_reg;

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    logic [CW_W-1:0]   chan_mem [CHANNELS];
    logic [CW_W-1:0]   chan_rdata_reg;
    logic [RING_W-1:0] ring_mem [CHANNELS * RING_DEPTH];
    logic [RING_W-1:0] ring_rdata_reg;

    logic              chan_re;
    logic              ring_re;
    logic              ring_we;
    logic [ADDR_W-1:0] ring_raddr;
    logic [ADDR_W-1:0] ring_waddr;
    logic [CW_W-1:0]   chan_wdata;
    logic [RING_W-1:0] ring_wdata;

    // ------------------------------------------------------------------
    // Current channel state, masked by the valid bits
    // ------------------------------------------------------------------
    logic [31:0]       mean_cur;
    logic [31:0]       dev_cur;
    logic [SLOT_W-1:0] wslot_cur;
    logic [LEN_W-1:0]  fill_cur;

    assign mean_cur  = chan_vld_reg ? chan_rdata_reg[31:0] : '0;
    assign dev_cur   = chan_vld_reg ? chan_rdata_reg[DEV_LSB +: 32] : '0;
    assign wslot_cur = ring_vld_reg ? chan_rdata_reg[WS_LSB +: SLOT_W] : '0;
    assign fill_cur  = ring_vld_reg ? chan_rdata_reg[FILL_LSB +: LEN_W] : '0;

    // write slot bookkeeping
    logic [SLOT_W-1:0] slot_use;
    logic [LEN_W-1:0]  slot_inc;
    logic [SLOT_W-1:0] wslot_nxt;
    logic [LEN_W-1:0]  fill_nxt;

    assign slot_use  = (LEN_W'(wslot_cur) >= len_eff) ? '0 : wslot_cur;
    assign slot_inc  = LEN_W'(slot_use) + LEN_W'(1);
    assign wslot_nxt = (slot_inc >= len_eff) ? '0 : SLOT_W'(slot_inc);
    assign fill_nxt  = (slot_inc > fill_cur) ? slot_inc : fill_cur;

    // EMA arithmetic
    logic [16:0] omega;                 // 1 - alpha, 1..65536
    logic [49:0] mean_sum;
    logic [49:0] dev_sum;
    logic [31:0] dev_new;
    logic [31:0] x_q16;

    assign omega    = emamd_pkg::ONE_Q16 - 17'(alpha_reg);
    assign mean_sum = 50'(keep_mean_reg) + {2'b00, take_mean_reg, 16'h0000};
    assign dev_sum  = 50'(keep_dev_reg) + 50'(take_dev_reg);
    assign dev_new  = dev_sum[47:16];
    assign x_q16    = {sample_reg, 16'h0000};

    // read result: stored pair only if the ring has been written that far
    logic rd_hit;

    assign rd_hit = ring_vld_reg && (LEN_W'(rslot_reg) < fill_cur);

    // ------------------------------------------------------------------
    // Output handshake
    // ------------------------------------------------------------------
    logic               m_tvalid_reg;
    logic               out_free;
    logic               out_load;
    emamd_pkg::result_t result_next;

    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = out_free &&
                      ((state_reg == S_CHAN && req_type_reg == emamd_pkg::REQ_READ) ||
                       (state_reg == S_DEVSUM) || (state_reg == S_REJECT));

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = result_reg;

    // result fields; a rejected request only carries its channel
    always_comb
    begin
        result_next             = '0;
        result_next.channel_out = channel_reg;
        case (state_reg)
            S_CHAN:
            begin
                result_next.mean_q16         = mean_cur;
                result_next.deviation_q16    = dev_cur;
                result_next.slot             = 11'(rslot_reg);
                result_next.stored_sample    = rd_hit ? ring_rdata_reg[15:0] : '0;
                result_next.stored_deviation = rd_hit ? ring_rdata_reg[47:16] : '0;
            end
            S_DEVSUM:
            begin
                result_next.mean_q16         = mean_new_reg;
                result_next.deviation_q16    = dev_new;
                result_next.slot             = 11'(slot_reg);
                result_next.stored_sample    = sample_reg;
                result_next.stored_deviation = dev_new;
            end
            default:
            begin
            end
        endcase
    end

    // memory control
    assign chan_re    = s_accept && ch_ok_in;
    assign ring_re    = s_accept && ch_ok_in && (s_tuser == emamd_pkg::REQ_READ);
    assign ring_we    = out_load && (state_reg == S_DEVSUM);
    assign ring_raddr = ADDR_W'(32'(idx_in) * RING_DEPTH) + ADDR_W'(rslot_in);
    assign ring_waddr = ADDR_W'(32'(idx_reg) * RING_DEPTH) + ADDR_W'(slot_reg);
    assign chan_wdata = {fill_next_reg, wslot_next_reg, dev_new, mean_new_reg};
    assign ring_wdata = {dev_new, sample_reg};

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            chan_mem[idx_reg] <= chan_wdata;
        end
        if (chan_re)
        begin
            chan_rdata_reg <= chan_mem[idx_in];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[ring_waddr] <= ring_wdata;
        end
        if (ring_re)
        begin
            ring_rdata_reg <= ring_mem[ring_raddr];
        end
    end

    // ------------------------------------------------------------------
    // Config registers and valid bits
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg      <= emamd_pkg::ALPHA_RESET;
            length_reg     <= emamd_pkg::LENGTH_RESET;
            chan_valid_reg <= '0;
            ring_valid_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    emamd_pkg::CFG_ALPHA_Q16:     alpha_reg  <= cfg_data[15:0];
                    emamd_pkg::CFG_LENGTH_IN_USE: length_reg <= cfg_data[11:0];
                    default:                      ;
                endcase
            end
            if (cfg_len_we)
            begin
                ring_valid_reg <= '0;
            end
            else if (ring_we)
            begin
                ring_valid_reg[idx_reg] <= 1'b1;
            end
            if (ring_we)
            begin
                chan_valid_reg[idx_reg] <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath pipeline (no reset)
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            req_type_reg  <= s_tuser;
            channel_reg   <= s_req.channel;
            sample_reg    <= s_req.sample;
            idx_reg       <= idx_in;
            rslot_reg     <= rslot_in;
            chan_vld_reg  <= ch_ok_in && chan_valid_reg[idx_in];
            ring_vld_reg  <= ch_ok_in && ring_valid_reg[idx_in];
            take_mean_reg <= 32'(alpha_reg) * 32'(s_req.sample);
        end

        case (state_reg)
            S_CHAN:
            begin
                keep_mean_reg  <= 49'(omega) * 49'(mean_cur);
                slot_reg       <= slot_use;
                wslot_next_reg <= wslot_nxt;
                fill_next_reg  <= fill_nxt;
            end
            S_MEAN:
            begin
                mean_new_reg <= mean_sum[47:16];
                keep_dev_reg <= 49'(omega) * 49'(dev_cur);
            end
            S_ABS:
            begin
                diff_reg <= (x_q16 >= mean_new_reg) ? (x_q16 - mean_new_reg)
                                                    : (mean_new_reg - x_q16);
            end
            S_DEVMUL:
            begin
                take_dev_reg <= 48'(alpha_reg) * 48'(diff_reg);
            end
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            result_reg <= result_next;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer and output valid
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (s_accept)
                    begin
                        state_reg <= ch_ok_in ? S_CHAN : S_REJECT;
                    end
                end
                S_CHAN:
                begin
                    if (req_type_reg == emamd_pkg::REQ_PUSH)
                    begin
                        state_reg <= S_MEAN;
                    end
                    else if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_MEAN:   state_reg <= S_ABS;
                S_ABS:    state_reg <= S_DEVMUL;
                S_DEVMUL: state_reg <= S_DEVSUM;
                S_DEVSUM, S_REJECT:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> (state_reg != S_IDLE))
        else $error("request accepted but sequencer stayed idle");

    a_write_only_push: assert property (@(posedge clk) disable iff (!rst_n)
        ring_we |-> (req_type_reg == emamd_pkg::REQ_PUSH && chan_vld_reg == $past(chan_vld_reg)))
        else $error("memory write-back outside a push");

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ring_we |-> (LEN_W'(slot_reg) < len_eff && fill_next_reg <= len_eff))
        else $error("ring write slot or fill beyond length in use");

    a_length_clears_ring: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_len_we |=> (ring_valid_reg == '0))
        else $error("length write did not clear ring state");

endmodule

`default_nettype wire

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for ema_mean_deviation_capture_top: per-channel EMA
// mean and mean absolute deviation with a capture ring per channel.
// ----------------------------------------------------------------------------
// A short scripted sequence hits reset state, sample extremes, alpha of zero,
// length writes of 0 and above the ring depth, slot wrap and reads past the
// length in use. Random phases follow, each with fresh register values and
// one of four mixes of sender gaps and receiver stalls. Every result is
// compared field by field against a local model of the channel state and
// the capture rings, or for some scripted rows a hand-written expectation.
// ----------------------------------------------------------------------------

module tb;

    localparam int NUM_CH         = 8;
    localparam int RING_WORDS     = 2048;
    localparam int PHASES         = 8;
    localparam int ITEMS_PER_PHASE = 210;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 8;

    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } row_kind_t;

    // One line of the scripted sequence
    typedef struct {
        row_kind_t             kind;
        logic                  req_kind;
        logic [2:0]            ch;
        logic [15:0]           smp;
        logic [10:0]           pos;
        emamd_pkg::cfg_index_t reg_idx;
        logic [15:0]           reg_val;
        bit                    typed;      // want holds a hand-written expectation
        emamd_pkg::result_t    want;
    } script_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tuser = emamd_pkg::REQ_PUSH;

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [127:0] m_tdata;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    emamd_pkg::cfg_index_t cfg_index = emamd_pkg::CFG_ALPHA_Q16;
    logic [emamd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    ema_mean_deviation_capture_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Channel model: averages, write slots, capture rings, registers
    // ------------------------------------------------------------------
    logic [31:0] mean_track   [NUM_CH];
    logic [31:0] spread_track [NUM_CH];
    logic [10:0] next_slot    [NUM_CH];
    logic [15:0] ring_sample  [NUM_CH][RING_WORDS];
    logic [31:0] ring_spread  [NUM_CH][RING_WORDS];
    logic [15:0] alpha_w  = emamd_pkg::ALPHA_RESET;
    logic [11:0] ring_len = emamd_pkg::LENGTH_RESET;

    emamd_pkg::result_t pending_results[$];

    int sender_idle_pct = 0;
    int stall_pct       = 0;
    int mismatch_count  = 0;
    int results_checked = 0;
    int push_count      = 0;
    int read_count      = 0;
    int cfg_count       = 0;
    int quiet_cycles    = 0;

    // (1 - a) * prev + a * target in Q16.16, truncated
    function automatic logic [31:0] ema_step(logic [31:0] prev, logic [31:0] target,
                                             logic [15:0] a);
        logic [63:0] keep;
        logic [63:0] take;
        logic [63:0] acc;
        keep = {47'd0, emamd_pkg::ONE_Q16 - {1'b0, a}} * {32'd0, prev};
        take = {48'd0, a} * {32'd0, target};
        acc  = keep + take;
        return acc[47:16];
    endfunction

    // Length 0 behaves as 1, anything past the ring depth as the depth
    function automatic logic [11:0] effective_span();
        if (ring_len == 12'd0)
            return 12'd1;
        if (ring_len > 12'(RING_WORDS))
            return 12'(RING_WORDS);
        return ring_len;
    endfunction

    function automatic void clear_rings();
        foreach (next_slot[c])
            next_slot[c] = '0;
        foreach (ring_sample[c, s])
        begin
            ring_sample[c][s] = '0;
            ring_spread[c][s] = '0;
        end
    endfunction

    // Applies one accepted request to the model and returns its result
    function automatic emamd_pkg::result_t advance_channel(logic kind, logic [2:0] ch,
                                                           logic [15:0] smp,
                                                           logic [10:0] pos);
        emamd_pkg::result_t r;
        logic [31:0]        x;
        logic [31:0]        m;
        logic [31:0]        d;
        logic [31:0]        dv;
        logic [10:0]        s;
        logic [11:0]        span;
        r = '0;
        r.channel_out = ch;
        if (kind == emamd_pkg::REQ_PUSH)
        begin
            x    = {smp, 16'h0000};
            m    = ema_step(mean_track[ch], x, alpha_w);
            d    = (x >= m) ? x - m : m - x;   // distance from the updated mean
            dv   = ema_step(spread_track[ch], d, alpha_w);
            span = effective_span();
            mean_track[ch]   = m;
            spread_track[ch] = dv;
            s = (12'(next_slot[ch]) >= span) ? 11'd0 : next_slot[ch];
            ring_sample[ch][s] = smp;
            ring_spread[ch][s] = dv;
            next_slot[ch] = (12'(s) + 12'd1 >= span) ? 11'd0 : s + 11'd1;
        end
        else
        begin
            s = pos;   // 11-bit position is already inside the ring depth
        end
        r.mean_q16         = mean_track[ch];
        r.deviation_q16    = spread_track[ch];
        r.slot             = s;
        r.stored_sample    = ring_sample[ch][s];
        r.stored_deviation = ring_spread[ch][s];
        return r;
    endfunction

    function automatic emamd_pkg::result_t blank_result(logic [2:0] ch, logic [10:0] s);
        emamd_pkg::result_t r;
        r = '0;
        r.channel_out = ch;
        r.slot        = s;
        return r;
    endfunction

    function automatic script_row_t req_row(logic kind, logic [2:0] ch,
                                            logic [15:0] smp, logic [10:0] pos);
        script_row_t r;
        r.kind     = ROW_REQ;
        r.req_kind = kind;
        r.ch       = ch;
        r.smp      = smp;
        r.pos      = pos;
        r.reg_idx  = emamd_pkg::CFG_ALPHA_Q16;
        r.reg_val  = '0;
        r.typed    = 1'b0;
        r.want     = '0;
        return r;
    endfunction

    function automatic script_row_t cfg_row(emamd_pkg::cfg_index_t idx, logic [15:0] value);
        script_row_t r;
        r = req_row(emamd_pkg::REQ_PUSH, 3'd0, 16'd0, 11'd0);
        r.kind    = ROW_CFG;
        r.reg_idx = idx;
        r.reg_val = value;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    task automatic send_request(logic kind, logic [2:0] ch, logic [15:0] smp,
                                logic [10:0] pos, bit typed, emamd_pkg::result_t want);
        emamd_pkg::req_t    payload;
        emamd_pkg::result_t predicted;
        payload          = '0;
        payload.channel  = ch;
        payload.sample   = smp;
        payload.position = pos;
        s_tvalid <= 1'b1;
        s_tdata  <= payload;
        s_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_tready);
        // transaction accepted at this edge; valid is left to the caller
        predicted = advance_channel(kind, ch, smp, pos);
        pending_results.push_back(typed ? want : predicted);
        if (kind == emamd_pkg::REQ_PUSH)
            push_count++;
        else
            read_count++;
    endtask

    // Register writes only go out once every result is back and the
    // pipeline has had time to settle
    task automatic write_reg(emamd_pkg::cfg_index_t idx, logic [15:0] value);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == emamd_pkg::CFG_ALPHA_Q16)
            alpha_w = value;
        else
        begin
            ring_len = value[11:0];
            clear_rings();   // length write zeroes write slots and stores
        end
        cfg_count++;
    endtask

    // ------------------------------------------------------------------
    // Result side: check, then pick the next m_tready
    // ------------------------------------------------------------------
    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_result(emamd_pkg::result_t got);
        emamd_pkg::result_t want;
        results_checked++;
        if (pending_results.size() == 0)
        begin
            $error("result transaction with no request outstanding");
            mismatch_count++;
        end
        else
        begin
            want = pending_results.pop_front();
            check_field("channel_out", 32'(want.channel_out), 32'(got.channel_out));
            check_field("mean_q16", want.mean_q16, got.mean_q16);
            check_field("deviation_q16", want.deviation_q16, got.deviation_q16);
            check_field("slot", 32'(want.slot), 32'(got.slot));
            check_field("stored_sample", 32'(want.stored_sample), 32'(got.stored_sample));
            check_field("stored_deviation", want.stored_deviation, got.stored_deviation);
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
                check_result(emamd_pkg::result_t'(m_tdata));
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: any accepted transaction on any channel resets the count
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        script_row_t script[$];
        script_row_t row;
        logic        kind;
        logic [2:0]  ch;
        logic [15:0] smp;
        logic [10:0] pos;
        logic [15:0] alpha_v;
        logic [11:0] len_v;
        int          alpha_plan [PHASES];
        int          length_plan [PHASES];
        int          idle_mode;

        // model state after reset
        foreach (mean_track[c])
        begin
            mean_track[c]   = '0;
            spread_track[c] = '0;
        end
        clear_rings();

        // --- scripted sequence ---
        // reset state: everything reads as zero
        row = req_row(emamd_pkg::REQ_READ, 3'd0, 16'hFFFF, 11'd0);
        row.typed = 1'b1;
        row.want  = blank_result(3'd0, 11'd0);
        script.push_back(row);
        row = req_row(emamd_pkg::REQ_READ, 3'd7, 16'h0000, 11'd2047);
        row.typed = 1'b1;
        row.want  = blank_result(3'd7, 11'd2047);
        script.push_back(row);
        // zero sample on a zeroed channel keeps it all zero
        row = req_row(emamd_pkg::REQ_PUSH, 3'd0, 16'h0000, 11'h7FF);
        row.typed = 1'b1;
        row.want  = blank_result(3'd0, 11'd0);
        script.push_back(row);
        script.push_back(req_row(emamd_pkg::REQ_PUSH, 3'd0, 16'hFFFF, 11'd0));
        script.push_back(req_row(emamd_pkg::REQ_PUSH, 3'd0, 16'hFFFF, 11'd5));
        script.push_back(req_row(emamd_pkg::REQ_READ, 3'd0, 16'd0, 11'd1));
        // alpha of zero: averages hold
        script.push_back(cfg_row(emamd_pkg::CFG_ALPHA_Q16, 16'd0));
        script.push_back(req_row(emamd_pkg::REQ_PUSH, 3'd0, 16'd12345, 11'd0));
        // heaviest weight, full swing on the top channel
        script.push_back(cfg_row(emamd_pkg::CFG_ALPHA_Q16, 16'hFFFF));
        script.push_back(req_row(emamd_pkg::REQ_PUSH, 3'd7, 16'hFFFF, 11'd0));
        script.push_back(req_row(emamd_pkg::REQ_PUSH, 3'd7, 16'h0000, 11'd0));
        // length of zero acts as one: rings cleared, every push hits slot 0
        script.push_back(cfg_row(emamd_pkg::CFG_LENGTH_IN_USE, 16'hF000));
        script.push_back(req_row(emamd_pkg::REQ_READ, 3'd0, 16'd0, 11'd0));
        script.push_back(req_row(emamd_pkg::REQ_PUSH, 3'd0, 16'd777, 11'd0));
        script.push_back(req_row(emamd_pkg::REQ_PUSH, 3'd0, 16'd778, 11'd0));
        // length beyond the ring depth is clamped
        script.push_back(cfg_row(emamd_pkg::CFG_LENGTH_IN_USE, 16'h0FFF));
        script.push_back(req_row(emamd_pkg::REQ_PUSH, 3'd3, 16'hAAAA, 11'd0));
        script.push_back(req_row(emamd_pkg::REQ_PUSH, 3'd3, 16'h5555, 11'd0));
        script.push_back(req_row(emamd_pkg::REQ_READ, 3'd3, 16'd0, 11'd1));
        // short ring: wrap, then a read past the length reads zero
        script.push_back(cfg_row(emamd_pkg::CFG_LENGTH_IN_USE, 16'd3));
        script.push_back(req_row(emamd_pkg::REQ_PUSH, 3'd5, 16'd100, 11'd0));
        script.push_back(req_row(emamd_pkg::REQ_PUSH, 3'd5, 16'd200, 11'd0));
        script.push_back(req_row(emamd_pkg::REQ_PUSH, 3'd5, 16'd300, 11'd0));
        script.push_back(req_row(emamd_pkg::REQ_PUSH, 3'd5, 16'd400, 11'd0));
        script.push_back(req_row(emamd_pkg::REQ_READ, 3'd5, 16'd0, 11'd2047));

        // per phase register values; -1 picks a random value
        alpha_plan  = '{65535, 1, -1, 32768, -1, -1, 1000, -1};
        length_plan = '{1, 2048, 16, 5, 4095, -1, 0, 2047};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].kind == ROW_CFG)
                write_reg(script[i].reg_idx, script[i].reg_val);
            else
                send_request(script[i].req_kind, script[i].ch, script[i].smp,
                             script[i].pos, script[i].typed, script[i].want);
        end

        // --- random phases ---
        for (int p = 0; p < PHASES; p++)
        begin
            alpha_v = (alpha_plan[p] < 0) ? 16'($urandom_range(65535, 1))
                                          : 16'(alpha_plan[p]);
            len_v   = (length_plan[p] < 0) ? 12'($urandom_range(64, 1))
                                           : 12'(length_plan[p]);
            write_reg(emamd_pkg::CFG_ALPHA_Q16, alpha_v);
            // upper bits of the data word are outside the register
            write_reg(emamd_pkg::CFG_LENGTH_IN_USE, {4'($urandom), len_v});

            idle_mode = p % 4;
            case (idle_mode)
                0: begin sender_idle_pct = 0;  stall_pct = 0;  end
                1: begin sender_idle_pct = 73; stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  stall_pct = 73; end
                default: begin sender_idle_pct = 24; stall_pct = 24; end
            endcase

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                kind = ($urandom_range(99) < 60) ? emamd_pkg::REQ_PUSH
                                                 : emamd_pkg::REQ_READ;
                ch   = 3'($urandom_range(NUM_CH - 1));
                case ($urandom_range(9))
                    0: smp = 16'h0000;
                    1: smp = 16'hFFFF;
                    default: smp = 16'($urandom);
                endcase
                // mostly read inside the length in use, sometimes anywhere
                if ($urandom_range(3) != 0)
                    pos = 11'($urandom_range(int'(effective_span()) - 1));
                else
                    pos = 11'($urandom);
                send_request(kind, ch, smp, pos, 1'b0, '0);
                while ($urandom_range(99) < sender_idle_pct)
                begin
                    s_tvalid <= 1'b0;
                    @(posedge clk);
                end
            end
        end
        s_tvalid <= 1'b0;

        // drain, then give any stray result time to show up
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Ran %0d pushes and %0d reads over %0d register writes, %0d results compared.",
                 push_count, read_count, cfg_count, results_checked);
        $display("Phases mixed sender gaps and receiver stalls at 0, 24 and 73 percent.");
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
